/* hdl/acas_pkg.sv */
package acas_pkg;

   // field and register widths
   localparam int TIME_W    = 17;
   localparam int REG_W     = 17;
   localparam int AXIS_W    = 16;
   localparam int QUOT_W    = 16;
   localparam int CSR_IDX_W = 2;

   // defaults for top level parameters and internal sizing
   localparam int NUM_PADDLES_DEFAULT = 2;
   localparam int QUEUE_DEPTH         = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VALID_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VALID_TIME = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN       = 2'd2;

   // register reset values
   localparam logic [REG_W-1:0] MIN_VALID_TIME_RST = 17'd100;
   localparam logic [REG_W-1:0] MAX_VALID_TIME_RST = 17'd100000;
   localparam logic [REG_W-1:0] MIN_SPAN_RST       = 17'd100;

   // axis constants
   localparam logic [AXIS_W-1:0] AXIS_OFFSET = 16'h8000;
   localparam logic [AXIS_W-1:0] AXIS_ZERO   = 16'h0000;

   // one job handed from the front end to the divider
   typedef struct packed {
      logic              needs_div;
      logic [AXIS_W-1:0] axis_const;
      logic [TIME_W-1:0] diff;
      logic [REG_W-1:0]  span;
      logic [TIME_W-1:0] low;
      logic [TIME_W-1:0] high;
   } job_type;

endpackage

/* hdl/acas_req_if.sv */
interface acas_req_if;
   import acas_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic              paddle;
   logic [TIME_W-1:0] elapsed_time;

   modport source (output valid, output action, output paddle, output elapsed_time,
                   input ready);
   modport sink   (input valid, input action, input paddle, input elapsed_time,
                   output ready);
endinterface

/* hdl/acas_rsp_if.sv */
interface acas_rsp_if;
   import acas_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [AXIS_W-1:0] axis;
   logic [TIME_W-1:0]        low_seen;
   logic [TIME_W-1:0]        high_seen;

   modport source (output valid, output axis, output low_seen, output high_seen,
                   input ready);
   modport sink   (input valid, input axis, input low_seen, input high_seen,
                   output ready);
endinterface

/* hdl/acas_csr_if.sv */
interface acas_csr_if;
   import acas_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [REG_W-1:0]     wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/acas_front.sv */
module acas_front #(
   parameter int NUM_PADDLES = acas_pkg::NUM_PADDLES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   acas_req_if.sink          req_bus,
   acas_csr_if.sink          csr_bus,
   input  logic              q_ready,
   output logic              q_push,
   output acas_pkg::job_type q_job
);
   import acas_pkg::*;

   localparam int IDX_W = (NUM_PADDLES > 1) ? $clog2(NUM_PADDLES) : 1;

   logic [REG_W-1:0]  min_valid_ff;
   logic [REG_W-1:0]  max_valid_ff;
   logic [REG_W-1:0]  min_span_ff;
   logic [TIME_W-1:0] low_mark_ff  [NUM_PADDLES];
   logic [TIME_W-1:0] high_mark_ff [NUM_PADDLES];

   logic              paddle_ok;
   logic [IDX_W-1:0]  idx;
   logic [TIME_W-1:0] t;
   logic [TIME_W-1:0] lo_cur;
   logic [TIME_W-1:0] hi_cur;
   logic              widen;
   logic [TIME_W-1:0] low_in;
   logic [TIME_W-1:0] high_in;
   logic              uncal;
   logic [TIME_W-1:0] t_clamp;
   logic [TIME_W-1:0] span_raw;
   logic [REG_W-1:0]  span_sel;
   logic              accept;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = q_ready;
   assign accept        = req_bus.valid & q_ready;

   // paddle lookup
   assign paddle_ok = int'(req_bus.paddle) < NUM_PADDLES;
   assign idx       = IDX_W'(req_bus.paddle);
   assign t         = req_bus.elapsed_time;
   assign lo_cur    = paddle_ok ? low_mark_ff[idx]  : '0;
   assign hi_cur    = paddle_ok ? high_mark_ff[idx] : '0;

   // widen marks with a valid sample, or restore them on a calibration reset
   assign widen = (t > min_valid_ff) && (t < max_valid_ff);

   always_comb begin
      if (req_bus.action) begin
         low_in  = max_valid_ff;
         high_in = min_valid_ff;
      end else begin
         low_in  = (widen && (t < lo_cur)) ? t : lo_cur;
         high_in = (widen && (t > hi_cur)) ? t : hi_cur;
      end
   end

   // clamp and span
   assign uncal    = high_in < low_in;
   assign t_clamp  = (t < low_in) ? low_in : ((t > high_in) ? high_in : t);
   assign span_raw = high_in - low_in;

   always_comb begin
      span_sel = (span_raw < min_span_ff) ? min_span_ff : span_raw;
      if (span_sel == '0) begin
         span_sel = REG_W'(1);
      end
   end

   // job for the divider
   always_comb begin
      q_push           = accept;
      q_job.needs_div  = paddle_ok && !req_bus.action && !uncal;
      q_job.axis_const = (paddle_ok && !req_bus.action && uncal) ? AXIS_OFFSET : AXIS_ZERO;
      q_job.diff       = t_clamp - low_in;
      q_job.span       = span_sel;
      q_job.low        = paddle_ok ? low_in  : '0;
      q_job.high       = paddle_ok ? high_in : '0;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_valid_ff <= MIN_VALID_TIME_RST;
         max_valid_ff <= MAX_VALID_TIME_RST;
         min_span_ff  <= MIN_SPAN_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            CSR_MIN_VALID_TIME: min_valid_ff <= csr_bus.wdata;
            CSR_MAX_VALID_TIME: max_valid_ff <= csr_bus.wdata;
            CSR_MIN_SPAN:       min_span_ff  <= csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

   // calibration marks
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PADDLES; i++) begin
            low_mark_ff[i]  <= MAX_VALID_TIME_RST;
            high_mark_ff[i] <= MIN_VALID_TIME_RST;
         end
      end else if (accept && paddle_ok) begin
         low_mark_ff[idx]  <= low_in;
         high_mark_ff[idx] <= high_in;
      end
   end

endmodule

/* hdl/acas_queue.sv */
module acas_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  acas_pkg::job_type push_job,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output acas_pkg::job_type pop_job
);
   import acas_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/acas_back.sv */
module acas_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  acas_pkg::job_type q_job,
   output logic              q_pop,
   acas_rsp_if.source        rsp_bus
);
   import acas_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W) + 1;
   localparam int NUM_W = TIME_W + QUOT_W;

   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } state_type;

   state_type         state_ff;
   logic [REG_W-1:0]  rem_ff;
   logic [QUOT_W-1:0] num_lo_ff;
   logic [QUOT_W-1:0] quo_ff;
   logic [REG_W-1:0]  span_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [TIME_W-1:0] low_ff;
   logic [TIME_W-1:0] high_ff;
   logic              out_valid_ff;
   logic [AXIS_W-1:0] axis_ff;
   logic [TIME_W-1:0] low_seen_ff;
   logic [TIME_W-1:0] high_seen_ff;

   logic              out_free;
   logic              out_load;
   logic [NUM_W-1:0]  num_in;
   logic [REG_W:0]    trial;
   logic              fits;
   logic [REG_W-1:0]  rem_in;
   logic [QUOT_W-1:0] quo_in;

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.axis      = axis_ff;
   assign rsp_bus.low_seen  = low_seen_ff;
   assign rsp_bus.high_seen = high_seen_ff;

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && (q_job.needs_div || out_free);

   // output register takes a response this cycle
   assign out_load = ((state_ff == ST_IDLE) && q_pop && !q_job.needs_div) ||
                     ((state_ff == ST_DIV) && (cnt_ff == '0) && out_free);

   // dividend is diff * 65535; its upper part is already below the divisor
   assign num_in = {q_job.diff, {QUOT_W{1'b0}}} - NUM_W'(q_job.diff);

   // one restoring division step
   assign trial  = {rem_ff, num_lo_ff[QUOT_W-1]};
   assign fits   = trial >= {1'b0, span_ff};
   assign rem_in = fits ? REG_W'(trial - {1'b0, span_ff}) : REG_W'(trial);
   assign quo_in = {quo_ff[QUOT_W-2:0], fits};

   // sequencer, divider and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (q_job.needs_div) begin
                     rem_ff    <= num_in[NUM_W-1:QUOT_W];
                     num_lo_ff <= num_in[QUOT_W-1:0];
                     quo_ff    <= '0;
                     span_ff   <= q_job.span;
                     low_ff    <= q_job.low;
                     high_ff   <= q_job.high;
                     cnt_ff    <= CNT_W'(QUOT_W);
                     state_ff  <= ST_DIV;
                  end else begin
                     axis_ff      <= q_job.axis_const;
                     low_seen_ff  <= q_job.low;
                     high_seen_ff <= q_job.high;
                  end
               end
            end
            ST_DIV: begin
               if (cnt_ff != '0) begin
                  rem_ff    <= rem_in;
                  quo_ff    <= quo_in;
                  num_lo_ff <= {num_lo_ff[QUOT_W-2:0], 1'b0};
                  cnt_ff    <= cnt_ff - CNT_W'(1);
               end else if (out_free) begin
                  axis_ff      <= quo_ff ^ AXIS_OFFSET;
                  low_seen_ff  <= low_ff;
                  high_seen_ff <= high_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hdl/auto_calibrating_axis_scaler.sv */
// channel   | bus      | direction | contents
// request   | req_bus  | in        | action, paddle, elapsed_time
// response  | rsp_bus  | out       | axis, low_seen, high_seen
// registers | csr_bus  | in        | reg_index, wdata (always ready)
//
// a scale request is classified and queued, popped by the back end, run through
// 16 steps of the serial restoring divider in the back end, then loaded into the output register
// calibration resets, uncalibrated paddles and bad paddle indexes skip the divider
// reset is synchronous: registers and marks return to defaults at once, no clearing pass
// a full queue stalls the request side; the output register holds a response until taken
module auto_calibrating_axis_scaler #(
   parameter int NUM_PADDLES = acas_pkg::NUM_PADDLES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   acas_req_if.sink   req_bus,
   acas_rsp_if.source rsp_bus,
   acas_csr_if.sink   csr_bus
);
   import acas_pkg::*;

   logic    push;
   job_type push_job;
   logic    push_ready;
   logic    pop;
   logic    pop_valid;
   job_type pop_job;

   // classify requests and keep the marks
   acas_front #(
      .NUM_PADDLES(NUM_PADDLES)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .csr_bus (csr_bus),
      .q_ready (push_ready),
      .q_push  (push),
      .q_job   (push_job)
   );

   // decoupling queue
   acas_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job)
   );

   // divide and respond
   acas_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (pop_valid),
      .q_job   (pop_job),
      .q_pop   (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

/* tb/axis_scaler_scoreboard.sv */
`timescale 1ns / 100ps

module axis_scaler_scoreboard #(
   parameter int NUM_PADDLES = acas_pkg::NUM_PADDLES_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   acas_req_if  req_bus,
   acas_rsp_if  rsp_bus,
   acas_csr_if  csr_bus,
   output int   failures,
   output int   pending,
   output int   checked
);
   import acas_pkg::*;

   localparam int AXIS_STEPS = 65535;
   localparam int AXIS_LOW   = -32768;
   localparam int AXIS_HIGH  = 32767;

   typedef struct packed {
      logic signed [AXIS_W-1:0] axis;
      logic [TIME_W-1:0]        low_seen;
      logic [TIME_W-1:0]        high_seen;
   } position_type;

   // shadow of the registers and of the per-paddle calibration marks
   logic [REG_W-1:0]  min_valid;
   logic [REG_W-1:0]  max_valid;
   logic [REG_W-1:0]  min_span;
   logic [TIME_W-1:0] low_mark  [NUM_PADDLES];
   logic [TIME_W-1:0] high_mark [NUM_PADDLES];

   // positions still owed by the block, oldest first
   position_type awaited_positions [$];

   // update the paddle's marks for one request and work out the position it reports
   function automatic position_type track_position(input logic recalibrate,
                                                   input int unsigned paddle,
                                                   input logic [TIME_W-1:0] elapsed);
      position_type        pos;
      logic [TIME_W-1:0]   lo;
      logic [TIME_W-1:0]   hi;
      logic [TIME_W-1:0]   t;
      logic [REG_W-1:0]    span;
      logic [TIME_W+15:0]  scaled;
      logic [TIME_W+15:0]  quotient;
      int                  axis_val;
      pos = '0;
      if (paddle >= NUM_PADDLES) return pos;
      if (recalibrate) begin
         low_mark[paddle]  = max_valid;
         high_mark[paddle] = min_valid;
         pos.axis = AXIS_ZERO;
      end else begin
         // only times strictly inside the valid window widen the marks
         if (elapsed > min_valid && elapsed < max_valid) begin
            if (elapsed < low_mark[paddle]) low_mark[paddle] = elapsed;
            if (elapsed > high_mark[paddle]) high_mark[paddle] = elapsed;
         end
         lo = low_mark[paddle];
         hi = high_mark[paddle];
         if (hi < lo) begin
            // uncalibrated: high mark below low mark
            pos.axis = AXIS_OFFSET;
         end else begin
            t = (elapsed < lo) ? lo : ((elapsed > hi) ? hi : elapsed);
            span = hi - lo;
            if (span < min_span) span = min_span;
            if (span == '0) span = REG_W'(1);
            scaled   = (TIME_W+16)'(t - lo) * (TIME_W+16)'(AXIS_STEPS);
            quotient = scaled / span;
            axis_val = int'(quotient) + AXIS_LOW;
            if (axis_val < AXIS_LOW) axis_val = AXIS_LOW;
            if (axis_val > AXIS_HIGH) axis_val = AXIS_HIGH;
            pos.axis = AXIS_W'(axis_val);
         end
      end
      pos.low_seen  = low_mark[paddle];
      pos.high_seen = high_mark[paddle];
      return pos;
   endfunction

   // watch all three channels at each rising edge
   always @(posedge clock) begin : watch
      position_type want;
      if (reset) begin
         min_valid = MIN_VALID_TIME_RST;
         max_valid = MAX_VALID_TIME_RST;
         min_span  = MIN_SPAN_RST;
         for (int i = 0; i < NUM_PADDLES; i++) begin
            low_mark[i]  = MAX_VALID_TIME_RST;
            high_mark[i] = MIN_VALID_TIME_RST;
         end
         awaited_positions.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.reg_index)
               CSR_MIN_VALID_TIME: min_valid = csr_bus.wdata;
               CSR_MAX_VALID_TIME: max_valid = csr_bus.wdata;
               CSR_MIN_SPAN:       min_span  = csr_bus.wdata;
               default: ;
            endcase
         end
         // response first so a request taken on the same edge cannot cover a stray one
         if (rsp_bus.valid && rsp_bus.ready) begin
            checked++;
            if (awaited_positions.size() == 0) begin
               $error("unexpected response: axis %0d, low_seen %0d, high_seen %0d",
                      rsp_bus.axis, rsp_bus.low_seen, rsp_bus.high_seen);
               failures++;
            end else begin
               want = awaited_positions.pop_front();
               if (rsp_bus.axis !== want.axis) begin
                  $error("axis mismatch: expected %0d, actual %0d", want.axis, rsp_bus.axis);
                  failures++;
               end
               if (rsp_bus.low_seen !== want.low_seen) begin
                  $error("low_seen mismatch: expected %0d, actual %0d",
                         want.low_seen, rsp_bus.low_seen);
                  failures++;
               end
               if (rsp_bus.high_seen !== want.high_seen) begin
                  $error("high_seen mismatch: expected %0d, actual %0d",
                         want.high_seen, rsp_bus.high_seen);
                  failures++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            awaited_positions.push_back(track_position(req_bus.action, req_bus.paddle,
                                                       req_bus.elapsed_time));
         end
      end
      pending = awaited_positions.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
   import acas_pkg::*;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 12;
   localparam int PHASE_REQUESTS = 118;
   localparam int SETTLE_CYCLES  = 30;
   localparam int CYCLE_LIMIT    = 500000;

   localparam logic [TIME_W-1:0]    TIME_MAX   = '1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic                 ACT_SCALE  = 1'b0;
   localparam logic                 ACT_RECAL  = 1'b1;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   failures;
   int   pending;
   int   checked;
   int   n_requests = 0;
   int   n_recal = 0;
   int   n_settings = 0;
   int   req_idle_pct = 0;
   int   rsp_idle_pct = 0;

   acas_req_if req_bus ();
   acas_rsp_if rsp_bus ();
   acas_csr_if csr_bus ();

   auto_calibrating_axis_scaler DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   axis_scaler_scoreboard scoreboard (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_bus  (rsp_bus),
      .csr_bus  (csr_bus),
      .failures (failures),
      .pending  (pending),
      .checked  (checked)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one request, with an optional random gap before it
   task automatic send_request(input logic action, input logic paddle,
                               input logic [TIME_W-1:0] elapsed);
      if ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.action       <= action;
      req_bus.paddle       <= paddle;
      req_bus.elapsed_time <= elapsed;
      do @(posedge clock); while (!req_bus.ready);
      n_requests++;
      if (action == ACT_RECAL) n_recal++;
   endtask

   // hold off until every response is back, then let the block settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all registers plus the unused index, valid held high across the burst
   task automatic write_regs(input logic [REG_W-1:0] min_v, input logic [REG_W-1:0] max_v,
                             input logic [REG_W-1:0] span);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [REG_W-1:0]     val [4];
      idx = '{CSR_MIN_VALID_TIME, CSR_MAX_VALID_TIME, CSR_MIN_SPAN, CSR_UNUSED};
      val = '{min_v, max_v, span, REG_W'($urandom)};
      for (int i = 0; i < 4; i++) begin
         csr_bus.valid     <= 1'b1;
         csr_bus.reg_index <= idx[i];
         csr_bus.wdata     <= val[i];
         do @(posedge clock); while (!csr_bus.ready);
      end
      csr_bus.valid <= 1'b0;
      n_settings++;
   endtask

   // new register setting, fresh calibration, then mostly in-window samples
   task automatic run_phase(input logic [REG_W-1:0] min_v, input logic [REG_W-1:0] max_v,
                            input logic [REG_W-1:0] span);
      int                pick;
      logic              paddle;
      logic [TIME_W-1:0] t;
      drain();
      write_regs(min_v, max_v, span);
      send_request(ACT_RECAL, 1'b0, TIME_W'($urandom));
      send_request(ACT_RECAL, 1'b1, TIME_W'($urandom));
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
         pick   = $urandom_range(99);
         paddle = 1'($urandom_range(1));
         if (pick < 4) begin
            send_request(ACT_RECAL, paddle, TIME_W'($urandom));
         end else begin
            if (pick < 10) begin
               // window edges and field extremes
               case ($urandom_range(3))
                  0: t = '0;
                  1: t = TIME_MAX;
                  2: t = min_v;
                  default: t = max_v;
               endcase
            end else if (pick < 30 || int'(max_v) <= int'(min_v) + 1) begin
               t = TIME_W'($urandom);
            end else begin
               t = TIME_W'($urandom_range(int'(max_v) - 1, int'(min_v) + 1));
            end
            send_request(ACT_SCALE, paddle, t);
         end
      end
   endtask

   // stimulus and verdict
   initial begin : stimulus
      logic [REG_W-1:0] lo_rand;
      logic [REG_W-1:0] hi_rand;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.action       <= ACT_SCALE;
      req_bus.paddle       <= 1'b0;
      req_bus.elapsed_time <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.reg_index    <= CSR_MIN_VALID_TIME;
      csr_bus.wdata        <= '0;
      req_idle_pct = 21;
      rsp_idle_pct = 53;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // uncalibrated paddle: below, above and on the window edges
      send_request(ACT_SCALE, 1'b0, '0);
      send_request(ACT_SCALE, 1'b0, TIME_MAX);
      send_request(ACT_SCALE, 1'b0, MIN_VALID_TIME_RST);
      send_request(ACT_SCALE, 1'b0, MAX_VALID_TIME_RST);
      // first sample gives zero span, floored by min_span
      send_request(ACT_SCALE, 1'b0, MIN_VALID_TIME_RST + 17'd1);
      send_request(ACT_SCALE, 1'b0, MAX_VALID_TIME_RST - 17'd1);
      send_request(ACT_SCALE, 1'b0, 17'd50050);
      // clamping to the marks
      send_request(ACT_SCALE, 1'b0, '0);
      send_request(ACT_SCALE, 1'b0, TIME_MAX);
      // narrow span on the other paddle
      send_request(ACT_SCALE, 1'b1, 17'd5000);
      send_request(ACT_SCALE, 1'b1, 17'd5050);
      send_request(ACT_SCALE, 1'b1, 17'd5025);
      // calibration reset, elapsed time ignored
      send_request(ACT_RECAL, 1'b0, TIME_MAX);
      send_request(ACT_SCALE, 1'b0, 17'd50000);
      send_request(ACT_SCALE, 1'b0, 17'd50000);
      send_request(ACT_RECAL, 1'b1, '0);
      send_request(ACT_SCALE, 1'b1, 17'd1);
      send_request(ACT_SCALE, 1'b1, 17'd101);

      run_phase(MIN_VALID_TIME_RST, MAX_VALID_TIME_RST, MIN_SPAN_RST);
      run_phase('0, TIME_MAX, 17'd1);
      run_phase('0, TIME_MAX, '0);

      req_idle_pct = 53;
      rsp_idle_pct = 21;
      run_phase(TIME_MAX, '0, TIME_MAX);
      lo_rand = REG_W'($urandom_range(60000));
      hi_rand = REG_W'($urandom_range(int'(TIME_MAX), int'(lo_rand)));
      run_phase(lo_rand, hi_rand, REG_W'($urandom_range(5000)));
      run_phase(17'd50000, 17'd50010, TIME_MAX);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      lo_rand = REG_W'($urandom_range(60000));
      hi_rand = REG_W'($urandom_range(int'(TIME_MAX), int'(lo_rand)));
      run_phase(lo_rand, hi_rand, REG_W'($urandom_range(TIME_MAX)));
      run_phase(17'd1000, 17'd2000, 17'd5);
      drain();

      $display("tb: %0d requests (%0d calibration resets) over %0d register settings",
               n_requests, n_recal, n_settings);
      $display("tb: %0d responses compared field by field, %0d mismatches",
               checked, failures);
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* auto_calibrating_axis_scaler.f */
hdl/acas_pkg.sv
hdl/acas_req_if.sv
hdl/acas_rsp_if.sv
hdl/acas_csr_if.sv
hdl/acas_front.sv
hdl/acas_queue.sv
hdl/acas_back.sv
hdl/auto_calibrating_axis_scaler.sv
tb/axis_scaler_scoreboard.sv
tb/tb.sv
